// File: hw/rtl/adsr_pkg.sv
`timescale 1ns / 1ps

package adsr_pkg;

	localparam int LEVEL_W = 15;
	localparam int STEP_W = 16;
	localparam int COUNT_W = 11;
	localparam int COUNT_MAX = (2 ** COUNT_W) - 1;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'd32767;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [2:0] REG_PEAK = 3'd0;
	localparam logic [2:0] REG_HOLD = 3'd1;
	localparam logic [2:0] REG_RISE = 3'd2;
	localparam logic [2:0] REG_FALL = 3'd3;
	localparam logic [2:0] REG_FADE = 3'd4;

	typedef enum logic [1:0] {
		KIND_ADVANCE  = 2'd0,
		KIND_START    = 2'd1,
		KIND_RELEASE  = 2'd2,
		KIND_REATTACK = 2'd3
	} kind_e;

	typedef enum logic [1:0] {
		PH_ATTACK  = 2'd0,
		PH_DECAY   = 2'd1,
		PH_SUSTAIN = 2'd2,
		PH_RELEASE = 2'd3
	} phase_e;

	typedef struct packed {
		kind_e              kind;
		logic [COUNT_W-1:0] num_samples;
	} item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] env_level;
		phase_e             env_phase;
	} result_t;

	typedef struct packed {
		logic [LEVEL_W-1:0]       peak_level;
		logic [LEVEL_W-1:0]       hold_level;
		logic [LEVEL_W-1:0]       rise_step;
		logic signed [STEP_W-1:0] fall_step;
		logic signed [STEP_W-1:0] fade_step;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic step;
		logic publish;
	} cmd_t;

	typedef struct packed {
		logic quantum_due;
	} stat_t;

	// clamp a widened signed sum into the unsigned level range
	function automatic logic [LEVEL_W-1:0] sat_level(input logic signed [17:0] v);
		logic [LEVEL_W-1:0] r;
		if (v < 18'sd0) begin
			r = '0;
		end else if (v > signed'({3'b000, LEVEL_MAX})) begin
			r = LEVEL_MAX;
		end else begin
			r = v[LEVEL_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/adsr_envelope_generator_top.sv
`timescale 1ns / 1ps

// ADSR envelope generator.
// Input channel item/item_valid/item_ready carries one command: advance by
// num_samples samples, start a note, release, or reattack. Every
// transaction returns one result (level and phase) on result/result_valid/
// result_ready. Envelope shape registers sit on the APB port (pready is
// always high). The user must write them only while the block is idle;
// the block itself does not enforce this. An item is accepted, each whole
// quantum is applied in turn, then the output register is loaded. The
// number of quanta an item completes is at most (QUANTUM - 1 + MAX_BLOCK) /
// QUANTUM, four at the default sizes. The single quantum update unit is the
// limiting loop. Start applies exactly one quantum; release and reattack
// apply none.
// A new item is accepted while an earlier result still waits in the output
// register; if the receiver stalls, processing halts before the output
// load until the register frees up.
// Reset clears level, phase (attack) and sample counter, drops result_valid
// and restores all shape registers to their full-scale defaults.

module adsr_envelope_generator_top #(
	parameter int QUANTUM = 256,
	parameter int MAX_BLOCK = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_ready,
	input  adsr_pkg::item_t             item,
	output logic                        result_valid,
	input  logic                        result_ready,
	output adsr_pkg::result_t           result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [adsr_pkg::ADDR_W-1:0] paddr,
	input  logic [adsr_pkg::DATA_W-1:0] pwdata,
	output logic [adsr_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);

	adsr_pkg::cfg_t  cfg;
	adsr_pkg::cmd_t  cmd;
	adsr_pkg::stat_t stat;

	adsr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	adsr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	adsr_datapath #(
		.QUANTUM   (QUANTUM),
		.MAX_BLOCK (MAX_BLOCK)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

endmodule

// File: hw/rtl/adsr_regs.sv
`timescale 1ns / 1ps

module adsr_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [adsr_pkg::ADDR_W-1:0] paddr,
	input  logic [adsr_pkg::DATA_W-1:0] pwdata,
	output logic [adsr_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output adsr_pkg::cfg_t              cfg
);

	adsr_pkg::cfg_t cfg_q;
	logic [2:0] idx;
	logic wr_en;

	assign pready = 1'b1;
	assign idx = paddr[4:2];
	assign wr_en = psel && penable && pwrite && pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.peak_level <= adsr_pkg::LEVEL_MAX;
			cfg_q.hold_level <= adsr_pkg::LEVEL_MAX;
			cfg_q.rise_step <= adsr_pkg::LEVEL_MAX;
			cfg_q.fall_step <= -16'sd32767;
			cfg_q.fade_step <= -16'sd32767;
		end else if (wr_en) begin
			unique case (idx)
				adsr_pkg::REG_PEAK: cfg_q.peak_level <= pwdata[14:0];
				adsr_pkg::REG_HOLD: cfg_q.hold_level <= pwdata[14:0];
				adsr_pkg::REG_RISE: cfg_q.rise_step <= pwdata[14:0];
				adsr_pkg::REG_FALL: cfg_q.fall_step <= signed'(pwdata[15:0]);
				adsr_pkg::REG_FADE: cfg_q.fade_step <= signed'(pwdata[15:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			adsr_pkg::REG_PEAK: prdata = {17'd0, cfg_q.peak_level};
			adsr_pkg::REG_HOLD: prdata = {17'd0, cfg_q.hold_level};
			adsr_pkg::REG_RISE: prdata = {17'd0, cfg_q.rise_step};
			adsr_pkg::REG_FALL: prdata = {{16{cfg_q.fall_step[15]}}, cfg_q.fall_step};
			adsr_pkg::REG_FADE: prdata = {{16{cfg_q.fade_step[15]}}, cfg_q.fade_step};
			default: prdata = '0;
		endcase
	end

endmodule

// File: hw/rtl/adsr_datapath.sv
`timescale 1ns / 1ps

module adsr_datapath #(
	parameter int QUANTUM = 256,
	parameter int MAX_BLOCK = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  adsr_pkg::item_t   item,
	input  adsr_pkg::cfg_t    cfg,
	input  adsr_pkg::cmd_t    cmd,
	output adsr_pkg::stat_t   stat,
	output adsr_pkg::result_t result
);

	// counter holds leftover samples plus the samples of the current transaction
	localparam int ACC_W = $clog2(QUANTUM + adsr_pkg::COUNT_MAX);
	localparam int CNT_CAP = (MAX_BLOCK < adsr_pkg::COUNT_MAX) ? MAX_BLOCK : adsr_pkg::COUNT_MAX;

	logic [adsr_pkg::LEVEL_W-1:0] level_q;
	adsr_pkg::phase_e             phase_q;
	logic [ACC_W-1:0]             acc_q;
	adsr_pkg::result_t            result_q;

	logic [adsr_pkg::COUNT_W-1:0] count_eff;
	logic [15:0]                  rise_sum;
	logic signed [17:0]           fall_sum;
	logic signed [17:0]           fade_sum;
	logic [adsr_pkg::LEVEL_W-1:0] nxt_level;
	adsr_pkg::phase_e             nxt_phase;

	assign count_eff = (item.num_samples > adsr_pkg::COUNT_W'(CNT_CAP))
		? adsr_pkg::COUNT_W'(CNT_CAP) : item.num_samples;

	assign rise_sum = {1'b0, level_q} + {1'b0, cfg.rise_step};
	assign fall_sum = signed'({3'b000, level_q}) + signed'({{2{cfg.fall_step[15]}}, cfg.fall_step});
	assign fade_sum = signed'({3'b000, level_q}) + signed'({{2{cfg.fade_step[15]}}, cfg.fade_step});

	always_comb begin
		nxt_level = level_q;
		nxt_phase = phase_q;
		case (phase_q)
			adsr_pkg::PH_ATTACK: begin
				if (rise_sum >= {1'b0, cfg.peak_level}) begin
					nxt_level = cfg.peak_level;
					nxt_phase = adsr_pkg::PH_DECAY;
				end else begin
					nxt_level = rise_sum[14:0];
				end
			end
			adsr_pkg::PH_DECAY: begin
				// a hold level above the current level still ends decay when fall_step is not positive
				if (fall_sum <= signed'({3'b000, cfg.hold_level})) begin
					nxt_level = cfg.hold_level;
					nxt_phase = adsr_pkg::PH_SUSTAIN;
				end else begin
					nxt_level = adsr_pkg::sat_level(fall_sum);
				end
			end
			adsr_pkg::PH_RELEASE: nxt_level = adsr_pkg::sat_level(fade_sum);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			phase_q <= adsr_pkg::PH_ATTACK;
			acc_q <= '0;
		end else if (cmd.load) begin
			case (item.kind)
				adsr_pkg::KIND_ADVANCE: acc_q <= acc_q + ACC_W'(count_eff);
				adsr_pkg::KIND_START: begin
					// one forced quantum from a cleared state
					level_q <= '0;
					phase_q <= adsr_pkg::PH_ATTACK;
					acc_q <= ACC_W'(QUANTUM);
				end
				adsr_pkg::KIND_RELEASE: phase_q <= adsr_pkg::PH_RELEASE;
				default: phase_q <= adsr_pkg::PH_ATTACK;
			endcase
		end else if (cmd.step) begin
			level_q <= nxt_level;
			phase_q <= nxt_phase;
			acc_q <= acc_q - ACC_W'(QUANTUM);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			result_q.env_level <= level_q;
			result_q.env_phase <= phase_q;
		end
	end

	assign stat.quantum_due = (acc_q >= ACC_W'(QUANTUM));
	assign result = result_q;

`ifndef SYNTHESIS
	a_step_consumes_quantum: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> acc_q == $past(acc_q) - ACC_W'(QUANTUM))
		else $error("quantum step did not consume one quantum");
	a_sustain_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && phase_q == adsr_pkg::PH_SUSTAIN) |=> $stable(level_q))
		else $error("sustain quantum moved the level");
	a_publish_level: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> (result.env_level == $past(level_q) && result.env_phase == $past(phase_q)))
		else $error("published result differs from state");
`endif

endmodule

// File: hw/rtl/adsr_ctrl.sv
`timescale 1ns / 1ps

module adsr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	output logic            result_valid,
	input  logic            result_ready,
	input  adsr_pkg::stat_t stat,
	output adsr_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || result_ready;
	assign item_ready = (state_q == S_IDLE);
	assign result_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d = S_RUN;
				end
			end
			S_RUN: begin
				if (stat.quantum_due) begin
					cmd.step = 1'b1;
				end else if (out_free) begin
					cmd.publish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> (state_q == S_RUN && !item_ready))
		else $error("accepted transaction did not start processing");
	a_publish_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |=> result_valid)
		else $error("published result not presented");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |-> !cmd.publish)
		else $error("pending result overwritten");
`endif

endmodule
